>>> rtl/wavvol_pkg.sv
// Package for the WAV PCM16 volume scaler: parser phase codes, result kinds,
// chunk tags, header magic, and the constants of the divide-by-100 step.
// Has no dependencies; used by wav_pcm16_volume_scaler_unit.
package wavvol_pkg;

	localparam int VOL_W = 7;
	localparam logic [VOL_W-1:0] VOL_RESET = 7'd60;

	localparam logic [31:0] RIFF_TAG = 32'h5249_4646;
	localparam logic [31:0] WAVE_TAG = 32'h5741_5645;
	localparam logic [31:0] FMT_TAG  = 32'h666D_7420;
	localparam logic [31:0] DATA_TAG = 32'h6461_7461;

	localparam logic [1:0] ST_SCALED  = 2'd0;
	localparam logic [1:0] ST_BAD_HDR = 2'd1;
	localparam logic [1:0] ST_NOT16   = 2'd2;
	localparam logic [1:0] ST_NO_DATA = 2'd3;

	// floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2^22.
	localparam int RECIP_SHIFT = 30;
	localparam logic [23:0] RECIP_100 = 24'd10737419;

	localparam logic [16:0] POS_MAX = 17'd32767;
	localparam logic [16:0] NEG_MAG_MAX = 17'd32768;

	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [5:0] {
		PH_HEADER = 6'b000001,
		PH_CHDR   = 6'b000010,
		PH_BODY   = 6'b000100,
		PH_PAD    = 6'b001000,
		PH_DATA   = 6'b010000,
		PH_PASS   = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		K_NONE = 2'd0,
		K_ONE  = 2'd1,
		K_PAIR = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [1:0] status;
	} beat_t;

endpackage

>>> rtl/wav_pcm16_volume_scaler_unit.sv
// WAV PCM16 volume scaler top level: RIFF chunk walker, sample gain with
// saturation, and an eight-beat output queue. Depends on wavvol_pkg.
//
// Channel   | Dir | Signals                          | Content
// ----------+-----+----------------------------------+---------------------------------
// s_*       | in  | s_tvalid s_tready s_tdata s_tlast | file byte, last-byte mark
// m_*       | out | m_tvalid m_tready m_tdata m_tlast | result byte, last mark, status
//           |     | m_tuser                          |
// cfg_*     | in  | cfg_wr_en cfg_wr_data            | volume_pct, write only
//
// One byte is accepted per cycle while s_tready is high. A byte goes through an
// input register, the parser and the sample multiplier, then a register that
// holds the divide by 100 and saturation, and is then written into the output
// queue. s_tready drops only when the queue cannot take the two beats that each
// byte in flight may produce, so the rate is set by the eight-entry queue and by
// m_tready. Reset is asynchronous and clears all parse state at once.
module wav_pcm16_volume_scaler_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,     // [7:0] in_byte
	input  logic                          s_tlast,     // in_last
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,     // [7:0] out_byte
	output logic                          m_tlast,     // out_last
	output logic [1:0]                    m_tuser,     // [1:0] result_status
	input  logic                          cfg_wr_en,
	input  logic [wavvol_pkg::VOL_W-1:0]  cfg_wr_data
);
	import wavvol_pkg::*;

	// Input register.
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	// Parse state.
	phase_t           phase_q, phase_n;
	logic [3:0]       idx_q, idx_n;
	logic             hok_q, hok_n;
	logic [31:0]      tag_q, tag_n;
	logic [31:0]      left_q, left_n;
	logic             pad_q, pad_n;
	logic [15:0]      bits_q, bits_n;
	logic [7:0]       hold_q, hold_n;
	logic [1:0]       scan_q, scan_n;
	logic [VOL_W-1:0] vol_q;

	// Result of the parse for the byte in s1.
	kind_t            kind;
	logic [7:0]       obyte;
	logic [1:0]       ostat;
	logic [7:0]       riff_b, wave_b;
	logic [15:0]      raw, absval;
	logic [22:0]      prod;

	// Scale stage.
	logic             valid_s2;
	kind_t            kind_s2;
	logic [7:0]       byte_s2;
	logic             last_s2;
	logic [1:0]       status_s2;
	logic [22:0]      mag_s2;
	logic             neg_s2;
	logic [46:0]      qprod;
	logic [16:0]      quo;
	logic [15:0]      scaled;

	// Output queue.
	beat_t            queue_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [1:0]       npush;
	logic             pop;
	logic [QCNT_W+1:0] credit;

	assign credit = {2'b00, count_q} + {{QCNT_W{1'b0}}, valid_s1, 1'b0}
		+ {{QCNT_W{1'b0}}, valid_s2, 1'b0};
	assign s_tready = (credit <= (QCNT_W+2)'(QDEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q <= VOL_RESET;
		end else if (cfg_wr_en) begin
			vol_q <= cfg_wr_data;
		end
	end

	assign riff_b = RIFF_TAG[5'd31 - {idx_q[1:0], 3'b000} -: 8];
	assign wave_b = WAVE_TAG[5'd31 - {idx_q[1:0], 3'b000} -: 8];

	always_comb begin
		phase_n = phase_q;
		idx_n   = idx_q;
		hok_n   = hok_q;
		tag_n   = tag_q;
		left_n  = left_q;
		pad_n   = pad_q;
		bits_n  = bits_q;
		hold_n  = hold_q;
		scan_n  = scan_q;
		kind    = K_ONE;
		obyte   = byte_s1;
		ostat   = ST_SCALED;
		case (phase_q)
			PH_HEADER: begin
				if (idx_q < 4'd4 && byte_s1 != riff_b) hok_n = 1'b0;
				if (idx_q >= 4'd8 && idx_q < 4'd12 && byte_s1 != wave_b) hok_n = 1'b0;
				if (idx_q >= 4'd11) begin
					idx_n = '0;
					if (hok_n) begin
						phase_n = PH_CHDR;
					end else begin
						phase_n = PH_PASS;
						scan_n  = ST_BAD_HDR;
					end
				end else begin
					idx_n = idx_q + 4'd1;
				end
			end
			PH_CHDR: begin
				if (idx_q == 4'd0) begin
					tag_n  = {24'd0, byte_s1};
					left_n = '0;
				end else if (idx_q < 4'd4) begin
					tag_n = {tag_q[23:0], byte_s1};
				end else if (idx_q < 4'd8) begin
					case (idx_q[1:0])
						2'd0:    left_n[7:0]   = byte_s1;
						2'd1:    left_n[15:8]  = byte_s1;
						2'd2:    left_n[23:16] = byte_s1;
						default: left_n[31:24] = byte_s1;
					endcase
				end
				if (idx_q >= 4'd7) begin
					idx_n = '0;
					pad_n = left_n[0];
					if (tag_n == DATA_TAG) begin
						scan_n  = ST_NOT16;
						phase_n = (bits_q != 16'd16 || left_n < 32'd2) ? PH_PASS : PH_DATA;
					end else begin
						if (tag_n == FMT_TAG && left_n < 32'd16) tag_n = '0;
						phase_n = (left_n == 32'd0) ? PH_CHDR : PH_BODY;
					end
				end else begin
					idx_n = idx_q + 4'd1;
				end
			end
			PH_BODY: begin
				if (tag_q == FMT_TAG) begin
					if (idx_q == 4'd14) begin
						hold_n = byte_s1;
					end else if (idx_q == 4'd15) begin
						bits_n = {byte_s1, hold_q};
						tag_n  = '0;
					end
				end
				if (idx_q < 4'd15) idx_n = idx_q + 4'd1;
				left_n = left_q - 32'd1;
				if (left_n == 32'd0) begin
					idx_n   = '0;
					phase_n = pad_q ? PH_PAD : PH_CHDR;
				end
			end
			PH_PAD: begin
				pad_n   = 1'b0;
				idx_n   = '0;
				phase_n = PH_CHDR;
			end
			PH_DATA: begin
				if (!idx_q[0]) begin
					if (left_q <= 32'd1) begin
						left_n  = '0;
						phase_n = PH_PASS;
					end else begin
						kind   = K_NONE;
						hold_n = byte_s1;
						idx_n  = 4'd1;
						left_n = left_q - 32'd1;
					end
				end else begin
					kind   = K_PAIR;
					idx_n  = '0;
					scan_n = ST_SCALED;
					left_n = left_q - 32'd1;
					if (left_n == 32'd0) phase_n = PH_PASS;
				end
			end
			default: begin
				kind = K_ONE;
			end
		endcase
		if (last_s1) begin
			ostat = (phase_n == PH_HEADER) ? ST_BAD_HDR : scan_n;
			// A file that ends on a held low byte still closes with one beat.
			if (kind == K_NONE) begin
				kind  = K_ONE;
				obyte = hold_n;
			end
			phase_n = PH_HEADER;
			idx_n   = '0;
			hok_n   = 1'b1;
			tag_n   = '0;
			left_n  = '0;
			pad_n   = 1'b0;
			bits_n  = '0;
			hold_n  = '0;
			scan_n  = ST_NO_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q   <= '0;
			hok_q   <= 1'b1;
			tag_q   <= '0;
			left_q  <= '0;
			pad_q   <= 1'b0;
			bits_q  <= '0;
			hold_q  <= '0;
			scan_q  <= ST_NO_DATA;
		end else if (valid_s1) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			hok_q   <= hok_n;
			tag_q   <= tag_n;
			left_q  <= left_n;
			pad_q   <= pad_n;
			bits_q  <= bits_n;
			hold_q  <= hold_n;
			scan_q  <= scan_n;
		end
	end

	// Sign and magnitude of the sample times the gain; the divide follows in s2.
	assign raw    = {byte_s1, hold_q};
	assign absval = raw[15] ? (16'd0 - raw) : raw;
	assign prod   = {7'd0, absval} * {16'd0, vol_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			kind_s2   <= kind;
			byte_s2   <= obyte;
			last_s2   <= last_s1;
			status_s2 <= ostat;
			mag_s2    <= prod;
			neg_s2    <= raw[15];
		end
	end

	assign qprod = {24'd0, mag_s2} * {23'd0, RECIP_100};
	assign quo   = qprod[RECIP_SHIFT +: 17];

	always_comb begin
		if (neg_s2) begin
			scaled = (quo >= NEG_MAG_MAX) ? 16'h8000 : (16'd0 - quo[15:0]);
		end else begin
			scaled = (quo > POS_MAX) ? 16'h7FFF : quo[15:0];
		end
	end

	always_comb begin
		npush = 2'd0;
		if (valid_s2) begin
			case (kind_s2)
				K_ONE:   npush = 2'd1;
				K_PAIR:  npush = 2'd2;
				default: npush = 2'd0;
			endcase
		end
	end

	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			if (kind_s2 == K_PAIR) begin
				queue_q[wptr_q]        <= '{data: scaled[7:0], last: 1'b0, status: ST_SCALED};
				queue_q[wptr_q + 1'b1] <= '{data: scaled[15:8], last: last_s2,
					status: status_s2};
			end else if (kind_s2 == K_ONE) begin
				queue_q[wptr_q] <= '{data: byte_s2, last: last_s2, status: status_s2};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + QPTR_W'(npush);
			if (pop) rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + QCNT_W'(npush) - QCNT_W'(pop);
		end
	end

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = queue_q[rptr_q].data;
	assign m_tlast  = queue_q[rptr_q].last;
	assign m_tuser  = queue_q[rptr_q].status;

	// The credit check on s_tready must keep the queue from overflowing.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("output queue overfilled");

	a_pair_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && kind_s2 == K_PAIR |-> count_q <= QCNT_W'(QDEPTH - 2))
		else $error("sample pushed without room for two beats");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 |=> phase_q == PH_HEADER && idx_q == 4'd0
			&& scan_q == ST_NO_DATA)
		else $error("parse state not cleared after last beat");

	a_pair_from_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && kind == K_PAIR |-> phase_q == PH_DATA && idx_q[0])
		else $error("sample result outside a data chunk");

	a_status_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == ST_SCALED)
		else $error("status on a beat that is not last");

endmodule

>>> tb/sv/wav_pcm16_volume_scaler_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for wav_pcm16_volume_scaler_unit: a directed table, then random WAV
// files at several gains, each output beat checked against the table or a behavioral parser.
// Depends on wavvol_pkg and on the unit itself.
module wav_pcm16_volume_scaler_unit_tb;
	import wavvol_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_START   = 700;
	localparam int HOLD_CYCLES  = 300;
	localparam int CALM_FIRST   = 1300;
	localparam int CALM_LAST    = 1800;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1450;
	localparam int N_GAINS      = 6;
	localparam int IDLE_PCT     = 11;
	localparam int MAX_REPORTS  = 10;
	localparam logic [3:0][15:0] EXTREME_SAMPLES =
		{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

	typedef struct packed {
		logic  typed;
		beat_t beat;
	} offer_tag_t;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
		logic       typed;
		logic [1:0] st;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;
	logic             s_tlast = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic             m_tlast;
	logic [1:0]       m_tuser;
	logic             cfg_wr_en = 1'b0;
	logic [VOL_W-1:0] cfg_wr_data = '0;

	// Behavioral parser state, mirrored from the unit.
	phase_t           par_phase;
	logic [3:0]       par_idx;
	logic             par_hdr_ok;
	logic [31:0]      par_tag;
	logic [31:0]      par_left;
	logic             par_pad;
	logic [15:0]      par_bits;
	logic [7:0]       par_hold;
	logic [1:0]       par_status;
	logic [VOL_W-1:0] par_gain;

	offer_tag_t offer_tags [$];
	beat_t      due_beats [$];
	int         errors = 0;
	int         cyc = 0;
	int         quiet_cycles = 0;

	wav_pcm16_volume_scaler_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic logic calm_window();
		return cyc >= CALM_FIRST && cyc < CALM_LAST;
	endfunction

	function automatic logic [15:0] gain_sample(input logic [15:0] raw,
			input logic [VOL_W-1:0] g);
		int prod;
		// SystemVerilog integer division truncates toward zero, as the unit must.
		prod = int'($signed(raw)) * int'(g) / 100;
		if (prod > 32767) prod = 32767;
		else if (prod < -32768) prod = -32768;
		return prod[15:0];
	endfunction

	task automatic restart_parse();
		par_phase  = PH_HEADER;
		par_idx    = '0;
		par_hdr_ok = 1'b1;
		par_tag    = '0;
		par_left   = '0;
		par_pad    = 1'b0;
		par_bits   = '0;
		par_hold   = '0;
		par_status = ST_NO_DATA;
	endtask

	// Advances the parser by one file byte and returns the zero to two beats it produces.
	task automatic parse_byte(input logic [7:0] b, input logic l, output beat_t res [2],
			output int n);
		int idx;
		logic [15:0] v;
		logic [1:0] st;
		idx = int'(par_idx);
		n = 0;
		res[0] = '0;
		res[1] = '0;
		case (par_phase)
		PH_HEADER: begin
			if (idx < 4 && b != RIFF_TAG[31 - 8 * idx -: 8]) par_hdr_ok = 1'b0;
			if (idx >= 8 && idx < 12 && b != WAVE_TAG[31 - 8 * (idx - 8) -: 8])
				par_hdr_ok = 1'b0;
			res[n].data = b;
			n++;
			if (idx >= 11) begin
				par_idx = '0;
				if (par_hdr_ok) begin
					par_phase = PH_CHDR;
				end else begin
					par_phase = PH_PASS;
					par_status = ST_BAD_HDR;
				end
			end else begin
				par_idx = 4'(idx + 1);
			end
		end
		PH_CHDR: begin
			res[n].data = b;
			n++;
			if (idx == 0) begin
				par_tag = {24'd0, b};
				par_left = '0;
			end else if (idx < 4) begin
				par_tag = {par_tag[23:0], b};
			end else if (idx < 8) begin
				par_left = par_left | ({24'd0, b} << (8 * (idx - 4)));
			end
			if (idx >= 7) begin
				par_idx = '0;
				par_pad = par_left[0];
				if (par_tag == DATA_TAG) begin
					par_status = ST_NOT16;
					par_phase = (par_bits != 16'd16 || par_left < 2) ? PH_PASS : PH_DATA;
				end else begin
					// A fmt chunk too short to hold bits-per-sample is walked but ignored.
					if (par_tag == FMT_TAG && par_left < 16) par_tag = '0;
					par_phase = (par_left == 0) ? PH_CHDR : PH_BODY;
				end
			end else begin
				par_idx = 4'(idx + 1);
			end
		end
		PH_BODY: begin
			res[n].data = b;
			n++;
			if (par_tag == FMT_TAG && idx == 14) begin
				par_hold = b;
			end else if (par_tag == FMT_TAG && idx == 15) begin
				par_bits = {b, par_hold};
				par_tag = '0;
			end
			if (idx < 15) par_idx = 4'(idx + 1);
			par_left = par_left - 1;
			if (par_left == 0) begin
				par_idx = '0;
				par_phase = par_pad ? PH_PAD : PH_CHDR;
			end
		end
		PH_PAD: begin
			res[n].data = b;
			n++;
			par_pad = 1'b0;
			par_idx = '0;
			par_phase = PH_CHDR;
		end
		PH_DATA: begin
			if (idx % 2 == 0) begin
				if (par_left <= 1) begin
					// The odd trailing byte of a data chunk is not scaled.
					res[n].data = b;
					n++;
					par_left = '0;
					par_phase = PH_PASS;
				end else begin
					par_hold = b;
					par_idx = 4'd1;
					par_left = par_left - 1;
				end
			end else begin
				v = gain_sample({b, par_hold}, par_gain);
				res[0].data = v[7:0];
				res[1].data = v[15:8];
				n = 2;
				par_idx = '0;
				par_status = ST_SCALED;
				par_left = par_left - 1;
				if (par_left == 0) par_phase = PH_PASS;
			end
		end
		default: begin
			res[n].data = b;
			n++;
		end
		endcase
		if (l) begin
			st = (par_phase == PH_HEADER) ? ST_BAD_HDR : par_status;
			// A file that ends on a held low byte releases it unscaled.
			if (n == 0) begin
				res[0].data = par_hold;
				n = 1;
			end
			res[n - 1].last = 1'b1;
			res[n - 1].status = st;
			restart_parse();
		end
	endtask

	task automatic put_word(ref logic [7:0] q [$], input logic [31:0] w, input logic big);
		for (int k = 0; k < 4; k++) q.push_back(big ? w[31 - 8 * k -: 8] : w[8 * k +: 8]);
	endtask

	// Writes a chunk header, len body bytes, and the pad byte when the body is complete and odd.
	task automatic put_chunk(ref logic [7:0] q [$], input logic [31:0] tag,
			input logic [31:0] size, input int len, input logic [15:0] bits);
		int i;
		logic [15:0] s;
		put_word(q, tag, 1'b1);
		put_word(q, size, 1'b0);
		i = 0;
		while (i < len) begin
			if (tag == FMT_TAG && i == 14 && len >= 16) begin
				q.push_back(bits[7:0]);
				q.push_back(bits[15:8]);
				i += 2;
			end else if (tag == DATA_TAG && i % 2 == 0 && i + 1 < len
					&& $urandom_range(3) == 0) begin
				s = EXTREME_SAMPLES[$urandom_range(3)];
				q.push_back(s[7:0]);
				q.push_back(s[15:8]);
				i += 2;
			end else begin
				q.push_back(8'($urandom));
				i++;
			end
		end
		if (size[0] && len == size) q.push_back(8'($urandom));
	endtask

	// Builds one random file: mostly well-formed, some with a broken header, some pure noise.
	task automatic make_file(ref logic [7:0] q [$]);
		int pick;
		int pos;
		int len;
		logic [31:0] size;
		q.delete();
		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 24)) q.push_back(8'($urandom));
			return;
		end
		put_word(q, RIFF_TAG, 1'b1);
		put_word(q, $urandom, 1'b0);
		put_word(q, WAVE_TAG, 1'b1);
		if (pick < 14) begin
			pos = $urandom_range(7);
			if (pos >= 4) pos += 4;
			q[pos] = q[pos] ^ (8'd1 << $urandom_range(7));
		end
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(3))
			0, 1: put_chunk(q, FMT_TAG, 16 + $urandom_range(0, 3), 16 + $urandom_range(0, 3),
					($urandom_range(3) != 0) ? 16'd16 : 16'($urandom));
			2: begin
				len = $urandom_range(0, 15);
				put_chunk(q, FMT_TAG, len, len, 16'd16);
			end
			default: begin
				len = $urandom_range(0, 6);
				put_chunk(q, $urandom, len, len, 16'd16);
			end
			endcase
		end
		if ($urandom_range(9) != 0) begin
			if ($urandom_range(11) == 0) begin
				// A huge declared size; the file ends somewhere inside the body.
				size = $urandom;
				len = $urandom_range(0, 20);
				if (size < len) len = size;
				put_chunk(q, DATA_TAG, size, len, 16'd0);
			end else begin
				len = $urandom_range(0, 17);
				put_chunk(q, DATA_TAG, len, len, 16'd0);
				if ($urandom_range(2) == 0) begin
					len = $urandom_range(0, 5);
					put_chunk(q, $urandom_range(1) ? DATA_TAG : 32'($urandom), len, len, 16'd0);
				end
			end
		end
		if ($urandom_range(6) == 0) begin
			len = $urandom_range(1, q.size());
			q = q[0:len - 1];
		end
	endtask

	task automatic offer_byte(input logic [7:0] b, input logic l, input logic typed,
			input beat_t want);
		while (!calm_window() && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		offer_tags.push_back({typed, want});
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
	endtask

	// Waits until every expected beat has come out, then lets in-flight bytes settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (due_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : watch_ports
		offer_tag_t tag;
		beat_t res [2];
		beat_t want;
		beat_t got;
		int n;
		if (arst_n) begin
			cyc++;
			quiet_cycles++;
			if (cfg_wr_en) par_gain = cfg_wr_data;
			if (s_tvalid && s_tready) begin
				quiet_cycles = 0;
				tag = offer_tags.pop_front();
				parse_byte(s_tdata, s_tlast, res, n);
				if (tag.typed) begin
					due_beats.push_back(tag.beat);
				end else begin
					for (int k = 0; k < n; k++) due_beats.push_back(res[k]);
				end
			end
			if (m_tvalid && m_tready) begin
				quiet_cycles = 0;
				got = {m_tdata, m_tlast, m_tuser};
				if (due_beats.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected beat byte %02h last %0d status %0d",
							$realtime, got.data, got.last, got.status);
				end else begin
					want = due_beats.pop_front();
					if (got != want) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: beat mismatch, expected %02h/%0d/%0d, got %02h/%0d/%0d",
								$realtime, want.data, want.last, want.status,
								got.data, got.last, got.status);
					end
				end
			end
		end
	end

	initial begin : sink
		int k;
		k = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			k++;
			if (k == HOLD_START) begin
				// Long back-pressure so the output queue fills and the input stalls.
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= calm_window() || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	initial begin : watchdog
		do @(posedge clk); while (quiet_cycles < STALL_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		dir_row_t dir_rows [$];
		logic [7:0] file_q [$];
		logic [VOL_W-1:0] gains [N_GAINS];
		int sent;
		restart_parse();
		par_gain = VOL_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rows with the typed flag set are pass-through beats; status only matters on a last row.
		// Single-byte files and a four-byte file all end inside the header.
		dir_rows.push_back({8'h00, 1'b1, 1'b1, ST_BAD_HDR});
		dir_rows.push_back({8'hFF, 1'b1, 1'b1, ST_BAD_HDR});
		dir_rows.push_back({8'h52, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h49, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h46, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h46, 1'b1, 1'b1, ST_BAD_HDR});
		// Good header with the largest RIFF size, then a data chunk with no fmt before it.
		dir_rows.push_back({8'h52, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h49, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h46, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h46, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'hFF, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'hFF, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'hFF, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'hFF, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h57, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h41, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h56, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h45, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h64, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h61, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h74, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h61, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h02, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h00, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h00, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h00, 1'b0, 1'b1, ST_SCALED});
		dir_rows.push_back({8'h00, 1'b0, 1'b0, ST_SCALED});
		dir_rows.push_back({8'h80, 1'b1, 1'b0, ST_SCALED});
		foreach (dir_rows[i])
			offer_byte(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed,
				{dir_rows[i].b, dir_rows[i].l, dir_rows[i].st});
		drain();

		gains[0] = 7'd100;
		gains[1] = 7'd0;
		gains[2] = 7'd127;
		gains[3] = 7'd1;
		gains[4] = 7'($urandom_range(2, 126));
		gains[5] = 7'($urandom_range(2, 99));
		for (int g = 0; g < N_GAINS; g++) begin
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= gains[g];
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			sent = 0;
			while (sent < RANDOM_ITEMS / N_GAINS) begin
				make_file(file_q);
				foreach (file_q[i]) offer_byte(file_q[i], i == file_q.size() - 1, 1'b0, '0);
				sent += file_q.size();
			end
			drain();
		end

		errors += due_beats.size();
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
